### hdl/lc3ie_pkg.sv
// Shared types, constants and a helper function of the LC-3 execute block.
`timescale 1ns / 1ps
`default_nettype none
package lc3ie_pkg;

    localparam logic [15:0] KBD_STATUS = 16'hFE00;
    localparam logic [15:0] KBD_DATA   = 16'hFE02;
    localparam logic [15:0] PC_DEFAULT = 16'h3000;
    localparam logic [15:0] KEY_WAIT   = 16'h8000;

    typedef enum logic [1:0] {
        ACT_WRITE   = 2'd0,
        ACT_READ    = 2'd1,
        ACT_EXECUTE = 2'd2,
        ACT_RESTART = 2'd3
    } t_action;

    typedef enum logic [3:0] {
        OP_BR   = 4'd0,
        OP_ADD  = 4'd1,
        OP_LD   = 4'd2,
        OP_ST   = 4'd3,
        OP_JSR  = 4'd4,
        OP_AND  = 4'd5,
        OP_LDR  = 4'd6,
        OP_STR  = 4'd7,
        OP_RTI  = 4'd8,
        OP_NOT  = 4'd9,
        OP_LDI  = 4'd10,
        OP_STI  = 4'd11,
        OP_JMP  = 4'd12,
        OP_RES  = 4'd13,
        OP_LEA  = 4'd14,
        OP_TRAP = 4'd15
    } t_op;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_READ,
        ST_FETCH,
        ST_EXEC,
        ST_MEM1,
        ST_MEM2
    } t_state;

    typedef struct packed {
        logic [1:0]  action;
        logic [15:0] address;
        logic [15:0] value;
        logic        key_ready;
        logic [7:0]  key_char;
    } t_in;

    typedef struct packed {
        logic [15:0] read_data;
        logic [15:0] next_pc;
        logic [15:0] executed_word;
        logic [2:0]  flags;
        logic        stored;
        logic [15:0] store_address;
        logic [15:0] store_data;
        logic        stopped;
    } t_out;

    function automatic logic [2:0] cc_of(input logic [15:0] v);
        logic [2:0] c;
        if (v == 16'd0) begin
            c = 3'd2;
        end else if (v[15]) begin
            c = 3'd4;
        end else begin
            c = 3'd1;
        end
        return c;
    endfunction

endpackage
`default_nettype wire

### hdl/lc3ie_mem.sv
// Single-port main memory with a registered read.
`timescale 1ns / 1ps
`default_nettype none
module lc3ie_mem #(
    parameter int DEPTH = 65536,
    parameter int AW    = $clog2(DEPTH)
) (
    input  wire logic          i_clk,
    input  wire logic          i_we,
    input  wire logic          i_re,
    input  wire logic [AW-1:0] i_addr,
    input  wire logic [15:0]   i_wdata,
    output logic [15:0]        o_rdata
);
    logic [15:0] r_mem [DEPTH];
    logic [15:0] r_q;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        if (i_re) begin
            r_q <= r_mem[i_addr];
        end
    end

    assign o_rdata = r_q;
endmodule
`default_nettype wire

### hdl/lc3ie_regfile.sv
// Eight general registers: two registered read ports, one write port, valid bits.
`timescale 1ns / 1ps
`default_nettype none
module lc3ie_regfile (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_re,
    input  wire logic [2:0]  i_ra,
    input  wire logic [2:0]  i_rb,
    input  wire logic        i_we,
    input  wire logic [2:0]  i_wa,
    input  wire logic [15:0] i_wdata,
    output logic [15:0]      o_qa,
    output logic [15:0]      o_qb
);
    logic [15:0] r_mem [8];
    logic [7:0]  r_valid;
    logic [15:0] r_qa;
    logic [15:0] r_qb;
    logic        r_va;
    logic        r_vb;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_we) begin
            r_valid[i_wa] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_wa] <= i_wdata;
        end
        if (i_re) begin
            r_qa <= r_mem[i_ra];
            r_qb <= r_mem[i_rb];
            r_va <= r_valid[i_ra];
            r_vb <= r_valid[i_rb];
        end
    end

    assign o_qa = r_va ? r_qa : 16'd0;
    assign o_qb = r_vb ? r_qb : 16'd0;
endmodule
`default_nettype wire

### hdl/lc3_instruction_execute.sv
// Top level of the LC-3 execute block: sequencer, keyboard words and result register.
//
//  Channel | Direction | Handshake                  | Word
//  in      | input     | i_in_valid / o_in_ready    | i_in_data  (t_in)
//  out     | output    | o_out_valid / i_out_ready  | o_out_data (t_out)
//  cfg     | input     | i_cfg_valid / o_cfg_ready  | i_cfg_data (start address)
//
// Write, restart and stopped executes finish in the accept cycle; a read waits in ST_READ
// for the registered memory word. An instruction steps through fetch, register read and
// execute, then up to two dependent data reads, as set by the single memory port. After
// reset a clearing pass zeroes all MEM_WORDS words before the first word is accepted.
// A stalled output holds the sequencer at its last step; a new word enters only when the
// result register is empty or is being read in the same cycle.
`timescale 1ns / 1ps
`default_nettype none
module lc3_instruction_execute #(
    parameter int MEM_WORDS = 65536
) (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_in_valid,
    output logic                 o_in_ready,
    input  wire lc3ie_pkg::t_in  i_in_data,
    output logic                 o_out_valid,
    input  wire logic            i_out_ready,
    output lc3ie_pkg::t_out      o_out_data,
    input  wire logic            i_cfg_valid,
    output logic                 o_cfg_ready,
    input  wire logic [15:0]     i_cfg_data
);
    localparam int AW = $clog2(MEM_WORDS);
    localparam logic [AW-1:0] SLOT_ST  = AW'(lc3ie_pkg::KBD_STATUS % MEM_WORDS);
    localparam logic [AW-1:0] SLOT_DT  = AW'(lc3ie_pkg::KBD_DATA % MEM_WORDS);
    localparam logic [AW-1:0] LAST_IDX = AW'(MEM_WORDS - 1);

    lc3ie_pkg::t_state r_state, n_state;
    logic [15:0] r_pc, n_pc;
    logic [2:0]  r_cc, n_cc;
    logic        r_stop, n_stop;
    logic [15:0] r_start;
    logic [15:0] r_ins, n_ins;
    lc3ie_pkg::t_in r_item, n_item;
    logic [AW-1:0] r_clr;
    logic        r_st_flag, n_st_flag, r_dt_flag, n_dt_flag;
    logic [15:0] r_st_val, n_st_val;
    logic [7:0]  r_dt_val, n_dt_val;
    logic        r_ovr, n_ovr;
    logic [15:0] r_ovr_val, n_ovr_val;
    lc3ie_pkg::t_out r_out, n_out;
    logic        r_out_valid;
    logic        push;

    logic        mem_we, mem_re;
    logic [15:0] mem_addr, mem_wdata, mem_q, rdat;
    logic        rd_kr;
    logic [7:0]  rd_kc;
    logic        rf_re, rf_we;
    logic [2:0]  rf_ra, rf_rb, rf_wa;
    logic [15:0] rf_wdata, ra, rb;

    logic        out_free;
    logic        fin;
    logic [15:0] f_pc, f_rval, f_sa, f_sd, f_rdata;
    logic        f_rwe, f_setcc, f_st, f_stop;
    logic [2:0]  f_rdr;
    lc3ie_pkg::t_op op;
    logic [15:0] pc1, off9, off6, off11, op2, ea9, ea6;

    lc3ie_mem #(.DEPTH(MEM_WORDS), .AW(AW)) u_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_re    (mem_re),
        .i_addr  (mem_addr[AW-1:0]),
        .i_wdata (mem_wdata),
        .o_rdata (mem_q)
    );

    lc3ie_regfile u_rf (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_re    (rf_re),
        .i_ra    (rf_ra),
        .i_rb    (rf_rb),
        .i_we    (rf_we),
        .i_wa    (rf_wa),
        .i_wdata (rf_wdata),
        .o_qa    (ra),
        .o_qb    (rb)
    );

    assign out_free    = !r_out_valid || i_out_ready;
    assign rdat        = r_ovr ? r_ovr_val : mem_q;
    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    assign op    = lc3ie_pkg::t_op'(r_ins[15:12]);
    assign pc1   = r_pc + 16'd1;
    assign off9  = {{7{r_ins[8]}}, r_ins[8:0]};
    assign off6  = {{10{r_ins[5]}}, r_ins[5:0]};
    assign off11 = {{5{r_ins[10]}}, r_ins[10:0]};
    assign op2   = r_ins[5] ? {{11{r_ins[4]}}, r_ins[4:0]} : rb;
    assign ea9   = pc1 + off9;
    assign ea6   = ra + off6;

    always_comb begin
        n_state   = r_state;
        n_pc      = r_pc;
        n_cc      = r_cc;
        n_stop    = r_stop;
        n_ins     = r_ins;
        n_item    = r_item;
        n_out     = r_out;
        push      = 1'b0;
        o_in_ready = 1'b0;
        mem_we    = 1'b0;
        mem_re    = 1'b0;
        mem_addr  = r_pc;
        mem_wdata = 16'd0;
        rd_kr     = r_item.key_ready;
        rd_kc     = r_item.key_char;
        rf_re     = 1'b0;
        rf_ra     = mem_q[8:6];
        rf_rb     = mem_q[2:0];
        fin       = 1'b0;
        f_pc      = pc1;
        f_rwe     = 1'b0;
        f_rdr     = r_ins[11:9];
        f_rval    = 16'd0;
        f_setcc   = 1'b0;
        f_st      = 1'b0;
        f_sa      = 16'd0;
        f_sd      = rb;
        f_stop    = r_stop;
        f_rdata   = 16'd0;

        case (r_state)
            lc3ie_pkg::ST_CLEAR: begin
                mem_we    = 1'b1;
                mem_addr  = 16'(r_clr);
                if (r_clr == LAST_IDX) begin
                    n_state = lc3ie_pkg::ST_IDLE;
                end
            end
            lc3ie_pkg::ST_IDLE: begin
                o_in_ready = out_free;
                rd_kr      = i_in_data.key_ready;
                rd_kc      = i_in_data.key_char;
                if (i_in_valid && out_free) begin
                    n_item = i_in_data;
                    n_out  = '{default: '0, next_pc: r_pc, flags: r_cc, stopped: r_stop};
                    case (lc3ie_pkg::t_action'(i_in_data.action))
                        lc3ie_pkg::ACT_WRITE: begin
                            mem_we    = 1'b1;
                            mem_addr  = i_in_data.address;
                            mem_wdata = i_in_data.value;
                            push      = 1'b1;
                        end
                        lc3ie_pkg::ACT_READ: begin
                            mem_re   = 1'b1;
                            mem_addr = i_in_data.address;
                            n_state  = lc3ie_pkg::ST_READ;
                        end
                        lc3ie_pkg::ACT_RESTART: begin
                            n_pc          = r_start;
                            n_stop        = 1'b0;
                            n_out.next_pc = r_start;
                            n_out.stopped = 1'b0;
                            push          = 1'b1;
                        end
                        default: begin
                            if (r_stop) begin
                                push = 1'b1;
                            end else begin
                                mem_re  = 1'b1;
                                n_state = lc3ie_pkg::ST_FETCH;
                            end
                        end
                    endcase
                end
            end
            lc3ie_pkg::ST_READ: begin
                if (out_free) begin
                    n_out = '{default: '0, read_data: rdat, next_pc: r_pc, flags: r_cc,
                              stopped: r_stop};
                    push    = 1'b1;
                    n_state = lc3ie_pkg::ST_IDLE;
                end
            end
            lc3ie_pkg::ST_FETCH: begin
                n_ins = rdat;
                rf_re = 1'b1;
                rf_ra = rdat[8:6];
                if (rdat[15:12] == lc3ie_pkg::OP_ST || rdat[15:12] == lc3ie_pkg::OP_STI ||
                    rdat[15:12] == lc3ie_pkg::OP_STR) begin
                    rf_rb = rdat[11:9];
                end else begin
                    rf_rb = rdat[2:0];
                end
                n_state = lc3ie_pkg::ST_EXEC;
            end
            lc3ie_pkg::ST_EXEC: begin
                case (op)
                    lc3ie_pkg::OP_BR: begin
                        fin = 1'b1;
                        if ((r_ins[11:9] & r_cc) != 3'd0) begin
                            f_pc = ea9;
                        end
                    end
                    lc3ie_pkg::OP_ADD: begin
                        fin = 1'b1; f_rwe = 1'b1; f_setcc = 1'b1; f_rval = ra + op2;
                    end
                    lc3ie_pkg::OP_AND: begin
                        fin = 1'b1; f_rwe = 1'b1; f_setcc = 1'b1; f_rval = ra & op2;
                    end
                    lc3ie_pkg::OP_NOT: begin
                        fin = 1'b1; f_rwe = 1'b1; f_setcc = 1'b1; f_rval = ~ra;
                    end
                    lc3ie_pkg::OP_LEA: begin
                        fin = 1'b1; f_rwe = 1'b1; f_setcc = 1'b1; f_rval = ea9;
                    end
                    lc3ie_pkg::OP_LD, lc3ie_pkg::OP_LDI, lc3ie_pkg::OP_STI: begin
                        mem_re = 1'b1; mem_addr = ea9; n_state = lc3ie_pkg::ST_MEM1;
                    end
                    lc3ie_pkg::OP_LDR: begin
                        mem_re = 1'b1; mem_addr = ea6; n_state = lc3ie_pkg::ST_MEM1;
                    end
                    lc3ie_pkg::OP_TRAP: begin
                        mem_re = 1'b1; mem_addr = {8'd0, r_ins[7:0]};
                        n_state = lc3ie_pkg::ST_MEM1;
                    end
                    lc3ie_pkg::OP_ST: begin
                        fin = 1'b1; f_st = 1'b1; f_sa = ea9;
                    end
                    lc3ie_pkg::OP_STR: begin
                        fin = 1'b1; f_st = 1'b1; f_sa = ea6;
                    end
                    lc3ie_pkg::OP_JMP: begin
                        fin = 1'b1; f_pc = ra;
                    end
                    lc3ie_pkg::OP_JSR: begin
                        fin = 1'b1; f_rwe = 1'b1; f_rdr = 3'd7; f_rval = pc1;
                        f_pc = r_ins[11] ? (pc1 + off11) : ra;
                    end
                    default: begin
                        fin = 1'b1; f_stop = 1'b1;
                    end
                endcase
            end
            lc3ie_pkg::ST_MEM1: begin
                case (op)
                    lc3ie_pkg::OP_LDI: begin
                        mem_re = 1'b1; mem_addr = rdat; n_state = lc3ie_pkg::ST_MEM2;
                    end
                    lc3ie_pkg::OP_STI: begin
                        fin = 1'b1; f_st = 1'b1; f_sa = rdat;
                    end
                    lc3ie_pkg::OP_TRAP: begin
                        fin = 1'b1; f_rwe = 1'b1; f_rdr = 3'd7; f_rval = pc1; f_pc = rdat;
                    end
                    default: begin
                        fin = 1'b1; f_rwe = 1'b1; f_setcc = 1'b1; f_rval = rdat;
                    end
                endcase
            end
            lc3ie_pkg::ST_MEM2: begin
                fin = 1'b1; f_rwe = 1'b1; f_setcc = 1'b1; f_rval = rdat;
            end
            default: begin
                n_state = lc3ie_pkg::ST_IDLE;
            end
        endcase

        rf_we    = fin && out_free && f_rwe;
        rf_wa    = f_rdr;
        rf_wdata = f_rval;
        if (fin && out_free) begin
            n_pc   = f_pc;
            n_stop = f_stop;
            if (f_setcc) begin
                n_cc = lc3ie_pkg::cc_of(f_rval);
            end
            if (f_st) begin
                mem_we    = 1'b1;
                mem_addr  = f_sa;
                mem_wdata = f_sd;
            end
            n_out = '{read_data: f_rdata, next_pc: f_pc, executed_word: r_ins,
                      flags: f_setcc ? lc3ie_pkg::cc_of(f_rval) : r_cc,
                      stored: f_st, store_address: f_st ? f_sa : 16'd0,
                      store_data: f_st ? f_sd : 16'd0, stopped: f_stop};
            push    = 1'b1;
            n_state = lc3ie_pkg::ST_IDLE;
        end
    end

    always_comb begin
        n_st_flag = r_st_flag;
        n_st_val  = r_st_val;
        n_dt_flag = r_dt_flag;
        n_dt_val  = r_dt_val;
        n_ovr     = r_ovr;
        n_ovr_val = r_ovr_val;
        if (mem_we && r_state != lc3ie_pkg::ST_CLEAR) begin
            if (mem_addr[AW-1:0] == SLOT_ST) begin
                n_st_flag = 1'b0;
            end
            if (mem_addr[AW-1:0] == SLOT_DT) begin
                n_dt_flag = 1'b0;
            end
        end
        if (mem_re) begin
            if (mem_addr == lc3ie_pkg::KBD_STATUS) begin
                n_st_flag = 1'b1;
                n_st_val  = rd_kr ? lc3ie_pkg::KEY_WAIT : 16'd0;
                if (rd_kr) begin
                    n_dt_flag = 1'b1;
                    n_dt_val  = rd_kc;
                end
            end
            n_ovr     = 1'b0;
            n_ovr_val = 16'd0;
            if (mem_addr[AW-1:0] == SLOT_ST && n_st_flag) begin
                n_ovr     = 1'b1;
                n_ovr_val = n_st_val;
            end else if (mem_addr[AW-1:0] == SLOT_DT && n_dt_flag) begin
                n_ovr     = 1'b1;
                n_ovr_val = {8'd0, n_dt_val};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= lc3ie_pkg::ST_CLEAR;
            r_clr       <= '0;
            r_pc        <= lc3ie_pkg::PC_DEFAULT;
            r_cc        <= 3'd0;
            r_stop      <= 1'b0;
            r_start     <= lc3ie_pkg::PC_DEFAULT;
            r_st_flag   <= 1'b0;
            r_dt_flag   <= 1'b0;
            r_ovr       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_clr     <= r_clr + AW'(1);
            r_pc      <= n_pc;
            r_cc      <= n_cc;
            r_stop    <= n_stop;
            r_st_flag <= n_st_flag;
            r_dt_flag <= n_dt_flag;
            r_ovr     <= n_ovr;
            if (i_cfg_valid) begin
                r_start <= i_cfg_data;
            end
            if (push) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_ins     <= n_ins;
        r_item    <= n_item;
        r_st_val  <= n_st_val;
        r_dt_val  <= n_dt_val;
        r_ovr_val <= n_ovr_val;
        r_out     <= n_out;
    end
endmodule
`default_nettype wire

### sim/tb_top.sv
// Self-checking testbench for the LC-3 execute block: directed and random programs.
`timescale 1ns / 1ps
`default_nettype none
module tb_top;

    localparam int WATCHDOG_LIMIT = 200000;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_in_valid = 1'b0;
    logic o_in_ready;
    lc3ie_pkg::t_in i_in_data = '0;
    logic o_out_valid;
    logic i_out_ready = 1'b0;
    lc3ie_pkg::t_out o_out_data;
    logic i_cfg_valid = 1'b0;
    logic o_cfg_ready;
    logic [15:0] i_cfg_data = '0;

    logic [15:0] mem_image [0:65535];
    logic [15:0] regs [0:7];
    logic [15:0] pc_q;
    logic [2:0] cc_q;
    logic halt_q;
    logic [15:0] start_q;

    lc3ie_pkg::t_out result_q [$];
    int errors = 0;
    int idle_cycles = 0;
    bit long_hold = 1'b0;
    bit burst_mode = 1'b1;

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    lc3_instruction_execute dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid), .o_in_ready(o_in_ready), .i_in_data(i_in_data),
        .o_out_valid(o_out_valid), .i_out_ready(i_out_ready), .o_out_data(o_out_data),
        .i_cfg_valid(i_cfg_valid), .o_cfg_ready(o_cfg_ready), .i_cfg_data(i_cfg_data)
    );

    function automatic logic [15:0] sx(input logic [15:0] v, input int bits);
        logic [15:0] r;
        r = v;
        for (int k = bits; k < 16; k++) r[k] = v[bits - 1];
        return r;
    endfunction

    function automatic logic [2:0] cond_of(input logic [15:0] v);
        if (v == 16'd0) return 3'd2;
        if (v[15]) return 3'd4;
        return 3'd1;
    endfunction

    function automatic logic [15:0] mem_fetch(input logic [15:0] a, input lc3ie_pkg::t_in w);
        if (a == lc3ie_pkg::KBD_STATUS) begin
            if (w.key_ready) begin
                mem_image[lc3ie_pkg::KBD_STATUS] = lc3ie_pkg::KEY_WAIT;
                mem_image[lc3ie_pkg::KBD_DATA] = {8'd0, w.key_char};
            end else begin
                mem_image[lc3ie_pkg::KBD_STATUS] = 16'd0;
            end
        end
        return mem_image[a];
    endfunction

    function automatic lc3ie_pkg::t_out predict_step(input lc3ie_pkg::t_in w);
        lc3ie_pkg::t_out r;
        logic [15:0] ins, npc, t, off9, off6, op2;
        logic [2:0] dr, sr1;
        lc3ie_pkg::t_op op;
        r = '0;
        case (lc3ie_pkg::t_action'(w.action))
            lc3ie_pkg::ACT_WRITE: mem_image[w.address] = w.value;
            lc3ie_pkg::ACT_READ: r.read_data = mem_fetch(w.address, w);
            lc3ie_pkg::ACT_RESTART: begin
                pc_q = start_q;
                halt_q = 1'b0;
            end
            default: if (!halt_q) begin
                ins = mem_fetch(pc_q, w);
                npc = pc_q + 16'd1;
                op = lc3ie_pkg::t_op'(ins[15:12]);
                dr = ins[11:9];
                sr1 = ins[8:6];
                off9 = sx(ins, 9);
                off6 = sx(ins, 6);
                op2 = ins[5] ? sx(ins, 5) : regs[ins[2:0]];
                r.executed_word = ins;
                case (op)
                    lc3ie_pkg::OP_BR: if ((ins[11:9] & cc_q) != 3'd0) npc = npc + off9;
                    lc3ie_pkg::OP_ADD: begin
                        regs[dr] = regs[sr1] + op2; cc_q = cond_of(regs[dr]);
                    end
                    lc3ie_pkg::OP_AND: begin
                        regs[dr] = regs[sr1] & op2; cc_q = cond_of(regs[dr]);
                    end
                    lc3ie_pkg::OP_NOT: begin
                        regs[dr] = ~regs[sr1]; cc_q = cond_of(regs[dr]);
                    end
                    lc3ie_pkg::OP_LD: begin
                        regs[dr] = mem_fetch(npc + off9, w);
                        cc_q = cond_of(regs[dr]);
                    end
                    lc3ie_pkg::OP_LDI: begin
                        t = mem_fetch(npc + off9, w);
                        regs[dr] = mem_fetch(t, w);
                        cc_q = cond_of(regs[dr]);
                    end
                    lc3ie_pkg::OP_LDR: begin
                        regs[dr] = mem_fetch(regs[sr1] + off6, w);
                        cc_q = cond_of(regs[dr]);
                    end
                    lc3ie_pkg::OP_LEA: begin
                        regs[dr] = npc + off9; cc_q = cond_of(regs[dr]);
                    end
                    lc3ie_pkg::OP_ST: begin
                        r.store_address = npc + off9; r.stored = 1'b1;
                    end
                    lc3ie_pkg::OP_STI: begin
                        r.store_address = mem_fetch(npc + off9, w); r.stored = 1'b1;
                    end
                    lc3ie_pkg::OP_STR: begin
                        r.store_address = regs[sr1] + off6; r.stored = 1'b1;
                    end
                    lc3ie_pkg::OP_JMP: npc = regs[sr1];
                    lc3ie_pkg::OP_JSR: begin
                        t = ins[11] ? npc + sx(ins, 11) : regs[sr1];
                        regs[7] = npc;
                        npc = t;
                    end
                    lc3ie_pkg::OP_TRAP: begin
                        regs[7] = npc;
                        npc = mem_fetch({8'd0, ins[7:0]}, w);
                    end
                    default: halt_q = 1'b1;
                endcase
                if (r.stored) begin
                    r.store_data = regs[dr];
                    mem_image[r.store_address] = r.store_data;
                end
                pc_q = npc;
            end
        endcase
        r.next_pc = pc_q;
        r.flags = cc_q;
        r.stopped = halt_q;
        return r;
    endfunction

    task automatic report_mismatch(input string what, input logic [15:0] got,
                                   input logic [15:0] want);
        $display("mismatch %s: got %h want %h", what, got, want);
        errors++;
    endtask

    task automatic send_word(input lc3ie_pkg::t_in w);
        if (!burst_mode && $urandom_range(0, 3) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(negedge i_clk);
        end
        if ($urandom_range(0, 15) == 0) burst_mode = ~burst_mode;
        i_in_data <= w;
        i_in_valid <= 1'b1;
        do @(posedge i_clk); while (!o_in_ready);
        result_q.push_back(predict_step(w));
        @(negedge i_clk);
    endtask

    task automatic send_op(input lc3ie_pkg::t_action a, input logic [15:0] adr,
                           input logic [15:0] val);
        lc3ie_pkg::t_in w;
        w.action = a;
        w.address = adr;
        w.value = val;
        w.key_ready = 1'($urandom_range(0, 1));
        w.key_char = 8'($urandom_range(0, 255));
        send_word(w);
    endtask

    task automatic drain();
        i_in_valid <= 1'b0;
        while (result_q.size() != 0) @(negedge i_clk);
        repeat (10) @(negedge i_clk);
    endtask

    task automatic write_start(input logic [15:0] a);
        i_cfg_data <= a;
        i_cfg_valid <= 1'b1;
        do @(posedge i_clk); while (!o_cfg_ready);
        start_q = a;
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // Loads a program word at the PC and executes it.
    task automatic run_instr(input logic [15:0] ins);
        send_op(lc3ie_pkg::ACT_WRITE, pc_q, ins);
        send_op(lc3ie_pkg::ACT_EXECUTE, 16'($urandom), 16'($urandom));
    endtask

    task automatic test_directed();
        send_op(lc3ie_pkg::ACT_EXECUTE, 16'h0000, 16'h0000);
        run_instr(16'h0E05);
        run_instr(16'h1020 | 16'h001F);
        run_instr(16'h1221 | 16'h000F);
        run_instr(16'h5401);
        run_instr(16'h967F);
        run_instr(16'h1A81);
        run_instr(16'h5B60);
        run_instr(16'hE7FF);
        run_instr(16'h3E00);
        run_instr(16'h7FFF);
        send_op(lc3ie_pkg::ACT_WRITE, 16'h00FE, 16'hFE00);
        run_instr(16'hF0FE);
        send_op(lc3ie_pkg::ACT_WRITE, 16'hFE00, 16'hFE00);
        send_op(lc3ie_pkg::ACT_READ, lc3ie_pkg::KBD_STATUS, 16'd0);
        send_op(lc3ie_pkg::ACT_READ, lc3ie_pkg::KBD_DATA, 16'd0);
        run_instr(16'h8000);
        send_op(lc3ie_pkg::ACT_EXECUTE, 16'd0, 16'd0);
        send_op(lc3ie_pkg::ACT_RESTART, 16'd0, 16'd0);
        run_instr(16'hD000);
        send_op(lc3ie_pkg::ACT_RESTART, 16'hFFFF, 16'hFFFF);
        drain();
    endtask

    task automatic test_random(input int count);
        int kind;
        for (int n = 0; n < count; n++) begin
            kind = $urandom_range(0, 19);
            if (kind == 0) send_op(lc3ie_pkg::ACT_RESTART, 16'($urandom), 16'($urandom));
            else if (kind < 3) send_op(lc3ie_pkg::ACT_READ, $urandom_range(0, 3) == 0 ?
                                       lc3ie_pkg::KBD_STATUS : 16'($urandom),
                                       16'($urandom));
            else if (kind < 5) send_op(lc3ie_pkg::ACT_WRITE, 16'($urandom), 16'($urandom));
            else if (kind < 7) send_op(lc3ie_pkg::ACT_EXECUTE, 16'($urandom), 16'($urandom));
            else begin
                // Stopping opcodes are kept rare so that programs run deep.
                logic [15:0] ins;
                ins = 16'($urandom);
                while ((ins[15:12] == lc3ie_pkg::OP_RTI || ins[15:12] == lc3ie_pkg::OP_RES)
                       && $urandom_range(0, 7) != 0) ins = 16'($urandom);
                if (halt_q && $urandom_range(0, 1) == 0)
                    send_op(lc3ie_pkg::ACT_RESTART, 16'd0, 16'd0);
                run_instr(ins);
            end
        end
        drain();
    endtask

    task automatic test_backpressure();
        long_hold = 1'b1;
        fork
            begin
                repeat (300) @(negedge i_clk);
                long_hold = 1'b0;
            end
            for (int n = 0; n < 8; n++) send_op(lc3ie_pkg::ACT_READ, 16'($urandom), 16'd0);
        join
        drain();
    endtask

    always @(negedge i_clk) begin
        if (long_hold) i_out_ready <= 1'b0;
        else i_out_ready <= ($urandom_range(0, 9) < 7) || ($urandom_range(0, 40) == 0);
    end

    always @(posedge i_clk) begin
        lc3ie_pkg::t_out want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (result_q.size() == 0) begin
                report_mismatch("unexpected word", o_out_data.next_pc, 16'd0);
            end else begin
                want = result_q.pop_front();
                if (o_out_data.read_data !== want.read_data)
                    report_mismatch("read_data", o_out_data.read_data, want.read_data);
                if (o_out_data.next_pc !== want.next_pc)
                    report_mismatch("next_pc", o_out_data.next_pc, want.next_pc);
                if (o_out_data.executed_word !== want.executed_word)
                    report_mismatch("executed_word", o_out_data.executed_word,
                                    want.executed_word);
                if (o_out_data.flags !== want.flags)
                    report_mismatch("flags", 16'(o_out_data.flags), 16'(want.flags));
                if (o_out_data.stored !== want.stored)
                    report_mismatch("stored", 16'(o_out_data.stored), 16'(want.stored));
                if (o_out_data.store_address !== want.store_address)
                    report_mismatch("store_address", o_out_data.store_address,
                                    want.store_address);
                if (o_out_data.store_data !== want.store_data)
                    report_mismatch("store_data", o_out_data.store_data, want.store_data);
                if (o_out_data.stopped !== want.stopped)
                    report_mismatch("stopped", 16'(o_out_data.stopped), 16'(want.stopped));
            end
        end
    end

    // The clearing pass after reset counts against the limit, so it is generous.
    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)
            || (i_cfg_valid && o_cfg_ready)) idle_cycles = 0;
        else idle_cycles++;
        if (idle_cycles > WATCHDOG_LIMIT) begin
            $display("tb_top: done, errors");
            $finish;
        end
    end

    initial begin
        for (int k = 0; k < 65536; k++) mem_image[k] = 16'd0;
        for (int k = 0; k < 8; k++) regs[k] = 16'd0;
        pc_q = lc3ie_pkg::PC_DEFAULT;
        cc_q = 3'd0;
        halt_q = 1'b0;
        start_q = lc3ie_pkg::PC_DEFAULT;
        repeat (3) @(negedge i_clk);
        i_rst_n <= 1'b1;
        test_directed();
        write_start(16'h0000);
        test_random(300);
        write_start(16'hFFFF);
        test_random(60);
        test_backpressure();
        write_start(16'($urandom));
        test_random(350);
        write_start(lc3ie_pkg::PC_DEFAULT);
        test_random(300);
        while (result_q.size() != 0) @(negedge i_clk);
        repeat (20) @(negedge i_clk);
        if (errors == 0) begin
            $display("tb_top: done, clean");
        end else begin
            $display("tb_top: done, errors");
        end
        $finish;
    end
endmodule
`default_nettype wire

### filelist.f
hdl/lc3ie_pkg.sv
hdl/lc3ie_mem.sv
hdl/lc3ie_regfile.sv
hdl/lc3_instruction_execute.sv
sim/tb_top.sv
